/* sv/cochlear_agc_stage_assert.svh */
// Assertion macros shared by the cochlear AGC stage RTL.
`ifndef COCHLEAR_AGC_STAGE_ASSERT_SVH
`define COCHLEAR_AGC_STAGE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and ignored during reset.
`define CAG_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and ignored during reset.
`define CAG_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/cag_pkg.sv */
// Types and constants of the cochlear AGC stage.
package cag_pkg;

  localparam int MAX_CHANNELS = 128;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int NCH_W        = CH_W + 1;

  localparam int SAMPLE_W  = 16;
  localparam int GOUT_W    = 16;
  localparam int CHAN_W    = 7;
  localparam int GAIN_W    = 17;
  localparam int EPS_W     = 16;
  localparam int EOT_W     = 24;
  localparam int NCFG_W    = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [GOUT_W-1:0] GOUT_MAX = 16'd32768;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SUM_W   = GAIN_W + 1;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SH, exact for x below 2^18.
  localparam logic [MUL_B_W-1:0] RECIP3    = 18'd174763;
  localparam int                 RECIP3_SH = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPSILON         = 2'd0,
    CFG_EPS_OVER_TARGET = 2'd1,
    CFG_CROSSTALK       = 2'd2,
    CFG_NUM_CHANNELS    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [GOUT_W-1:0] gain_out;
    logic [CHAN_W-1:0] channel;
    logic              frame_end;
  } out_t;

endpackage

/* sv/cag_if.sv */
// Valid/ready stream interfaces for the sample input and the result output.
interface cag_in_if import cag_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cag_out_if import cag_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/cag_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cag_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cochlear_agc_stage.sv */
// Top level of the cochlear AGC stage: sequencer, shared multiplier, gain store.
//
//   channel    dir  payload                        request accepted when
//   sample_i   in   sample (Q4.12 signed)          valid && ready
//   result_o   out  gain_out, channel, frame_end   valid && ready
//   cfg_*      in   index, data (no read-back)     cfg_we_i high
//
// Each request occupies the block through these steps: the accept, two reads of the
// gain store (own channel, then right neighbor) and five passes through the one
// shared 24x18 multiplier, then a write-back step. The block is ready again only
// in the idle state. Write-back waits while an earlier result is still held in the
// output register, so a stalled sink adds cycles one for one. Reset clears the
// per-entry valid flags of the gain store at once, so no clearing pass follows it.
module cochlear_agc_stage import cag_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  cag_in_if.sink               sample_i,
  cag_out_if.source            result_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request, own gain read issued
  localparam logic [2:0] S_GOWN = 3'd1;  // own gain arrives, right neighbor read issued
  localparam logic [2:0] S_GRGT = 3'd2;  // neighbor sum formed, |x| * (1 - g)
  localparam logic [2:0] S_MB   = 3'd3;  // round gain_out, sum / 3 quotient
  localparam logic [2:0] S_MC   = 3'd4;  // remainder correction k * r / 3
  localparam logic [2:0] S_MD   = 3'd5;  // k * quotient (or k * g)
  localparam logic [2:0] S_ME   = 3'd6;  // gain_out * eps_over_target
  localparam logic [2:0] S_WB   = 3'd7;  // clamp, write back, present result

  // Configuration registers.
  logic [EPS_W-1:0]  eps_q;
  logic [EOT_W-1:0]  eot_q;
  logic              xt_q;
  logic [NCFG_W-1:0] nch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(655);
      eot_q <= EOT_W'(6553);
      xt_q  <= 1'b1;
      nch_q <= NCFG_W'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EPSILON:         eps_q <= cfg_wdata_i[EPS_W-1:0];
        CFG_EPS_OVER_TARGET: eot_q <= cfg_wdata_i[EOT_W-1:0];
        CFG_CROSSTALK:       xt_q  <= cfg_wdata_i[0];
        CFG_NUM_CHANNELS:    nch_q <= cfg_wdata_i[NCFG_W-1:0];
      endcase
    end
  end

  // A channel count of zero behaves as one, and counts beyond the store size
  // behave as the store size.
  logic [NCH_W-1:0] n_eff;

  always_comb begin
    if (nch_q == '0) begin
      n_eff = NCH_W'(1);
    end else if (32'(nch_q) > MAX_CHANNELS) begin
      n_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      n_eff = NCH_W'(nch_q);
    end
  end

  // Sequencer and datapath registers.
  logic [2:0]          state_q, state_d;
  logic [CH_W-1:0]     cnt_q;
  logic [GAIN_W-1:0]   lold_q;
  logic [CH_W-1:0]     c_q;
  logic                last_q;
  logic [GOUT_W-1:0]   mag_q;
  logic [GAIN_W-1:0]   g_q;
  logic [SUM_W-1:0]    s_q;
  logic [GOUT_W-1:0]   gout_q;
  logic [GAIN_W-1:0]   q_q;
  logic [GAIN_W-1:0]   fr_q;
  logic [ACC_W-1:0]    acc_q;
  logic [PROD_W-1:0]   prod_q;
  logic [MAX_CHANNELS-1:0] vld_q;
  logic                rvld_q;
  logic                out_vld_q;
  out_t                out_q;

  logic acc_fire;
  logic wb_fire;
  logic out_free;

  assign sample_i.ready = (state_q == S_IDLE);
  assign acc_fire       = sample_i.valid && sample_i.ready;
  assign out_free       = !out_vld_q || result_o.ready;
  assign wb_fire        = (state_q == S_WB) && out_free;

  // If the channel count was lowered mid frame, the index wraps before use.
  logic [CH_W-1:0] c_acc;
  logic            last_acc;

  assign c_acc    = ({1'b0, cnt_q} >= n_eff) ? '0 : cnt_q;
  assign last_acc = (NCH_W'({1'b0, c_acc}) + NCH_W'(1)) >= n_eff;

  // Sample magnitude: -32768 maps to 32768, which still fits 16 bits unsigned.
  logic [GOUT_W-1:0] mag_acc;

  assign mag_acc = sample_i.data.sample[SAMPLE_W-1]
                 ? GOUT_W'(~sample_i.data.sample + SAMPLE_W'(1))
                 : GOUT_W'(sample_i.data.sample);

  // Gain store. Entries never written since reset read as zero.
  logic [CH_W-1:0]   raddr;
  logic [GAIN_W-1:0] rdata;
  logic [GAIN_W-1:0] g_rd;
  logic [GAIN_W-1:0] ng;

  always_comb begin
    if (state_q == S_IDLE) begin
      raddr = c_acc;
    end else begin
      raddr = CH_W'({1'b0, c_q} + NCH_W'(1));
    end
  end

  cag_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (MAX_CHANNELS)
  ) u_gain_ram (
    .clk_i   (clk_i),
    .we_i    (wb_fire),
    .waddr_i (c_q),
    .wdata_i (ng),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign g_rd = rvld_q ? rdata : '0;

  // Neighbor sum. The first channel uses its own gain on the left, the last one
  // uses its own gain on the right.
  logic [GAIN_W-1:0] left_g;
  logic [GAIN_W-1:0] right_g;
  logic [SUM_W-1:0]  s_now;

  assign left_g  = (c_q == '0) ? g_q : lold_q;
  assign right_g = last_q ? g_q : g_rd;
  assign s_now   = SUM_W'(left_g) + SUM_W'(g_q) + SUM_W'(right_g);

  // Decay factor k = 1 - epsilon, in Q1.16.
  logic [GAIN_W-1:0] k;

  assign k = ONE_Q16 - {1'b0, eps_q};

  // Divide-by-three split: sum = 3q + r, so k * sum / 3 = k * q + floor(k * r / 3).
  logic [GAIN_W-1:0] q_now;
  logic [SUM_W-1:0]  r_full;
  logic [1:0]        r;
  logic [SUM_W-1:0]  rk;

  assign q_now  = prod_q[RECIP3_SH +: GAIN_W];
  assign r_full = s_q - ({q_now, 1'b0} + {1'b0, q_now});
  assign r      = r_full[1:0];

  always_comb begin
    case (r)
      2'd1:    rk = {1'b0, k};
      2'd2:    rk = {k, 1'b0};
      default: rk = '0;
    endcase
  end

  // The shared multiplier; its product is always registered before use.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  always_comb begin
    unique case (state_q) inside
      S_GRGT: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(ONE_Q16 - g_q);
      end
      S_MB: begin
        mul_a = MUL_A_W'(s_q);
        mul_b = RECIP3;
      end
      S_MC: begin
        mul_a = MUL_A_W'(rk);
        mul_b = RECIP3;
      end
      S_MD: begin
        mul_a = MUL_A_W'(k);
        mul_b = MUL_B_W'(q_q);
      end
      S_ME: begin
        mul_a = eot_q;
        mul_b = MUL_B_W'(gout_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Rounded gain_out from |x| * (1 - g).
  logic [PROD_W-1:0] gsum;

  assign gsum = prod_q + PROD_W'(32768);

  // New gain: gain_out * eps_over_target * 16 + decay, rounded and clamped to one.
  logic [ACC_W-1:0]        total;
  logic [ACC_W-16-1:0]     total_hi;

  assign total    = acc_q + ACC_W'({prod_q, 4'b0000});
  assign total_hi = total[ACC_W-1:16];
  assign ng       = (total_hi > (ACC_W-16)'(ONE_Q16)) ? ONE_Q16 : total_hi[GAIN_W-1:0];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      S_IDLE: if (acc_fire) state_d = S_GOWN;
      S_GOWN: state_d = S_GRGT;
      S_GRGT: state_d = S_MB;
      S_MB:   state_d = S_MC;
      S_MC:   state_d = S_MD;
      S_MD:   state_d = S_ME;
      S_ME:   state_d = S_WB;
      S_WB:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      lold_q    <= '0;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= vld_q[raddr];
      if (wb_fire) begin
        vld_q[c_q] <= 1'b1;
        lold_q     <= g_q;
        cnt_q      <= last_q ? '0 : CH_W'({1'b0, c_q} + NCH_W'(1));
        out_vld_q  <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers carry payload only and take no reset.
  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      c_q    <= c_acc;
      last_q <= last_acc;
      mag_q  <= mag_acc;
    end
    unique case (state_q) inside
      S_GOWN: g_q <= g_rd;
      S_GRGT: begin
        s_q    <= s_now;
        prod_q <= mul_p;
      end
      S_MB: begin
        gout_q <= gsum[16 +: GOUT_W];
        prod_q <= mul_p;
      end
      S_MC: begin
        q_q    <= xt_q ? q_now : g_q;
        prod_q <= mul_p;
      end
      S_MD: begin
        fr_q   <= xt_q ? prod_q[RECIP3_SH +: GAIN_W] : '0;
        prod_q <= mul_p;
      end
      S_ME: begin
        acc_q  <= ACC_W'(prod_q) + ACC_W'(fr_q) + ACC_W'(32768);
        prod_q <= mul_p;
      end
      default: ;
    endcase
    if (wb_fire) begin
      out_q.gain_out  <= gout_q;
      out_q.channel   <= CHAN_W'(c_q);
      out_q.frame_end <= last_q;
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

  // The reciprocal multiply must leave a remainder of 0, 1 or 2, and the rounded
  // magnitude can never exceed 8.0 in Q4.12.
  `include "cochlear_agc_stage_assert.svh"

  `CAG_ASSERT_IMPL(a_recip_rem, (state_q == S_MC) && xt_q, r_full < SUM_W'(3), "sum divided by three left a bad remainder")
  `CAG_ASSERT_IMPL(a_gout_range, state_q == S_MC, gout_q <= GOUT_MAX, "gain_out above full scale")
  `CAG_ASSERT_NEXT(a_frame_wrap, wb_fire && last_q, cnt_q == '0, "channel count did not wrap at frame end")
  `CAG_ASSERT_NEXT(a_result_load, wb_fire, result_o.valid && (result_o.data.channel == CHAN_W'(c_q)), "result not presented after write-back")

endmodule
